// ===== hw/rtl/lru_pkg.sv =====
// shared widths, constants and the result beat type for the lru page replacement block
package lru_pkg;

  localparam int MAX_FRAMES = 8;
  localparam int OCC_W      = $clog2(MAX_FRAMES + 1);
  localparam int PAGE_W     = 8;
  localparam int CFG_W      = 4;
  localparam int CNT_W      = 32;

  localparam logic [CFG_W-1:0] FRAMES_RESET = CFG_W'(4);

  typedef struct packed {
    logic              hit;
    logic              evicted_valid;
    logic [PAGE_W-1:0] evicted_page;
    logic [CNT_W-1:0]  hit_total;
    logic [CNT_W-1:0]  fault_total;
  } lru_result_t;

endpackage

// ===== hw/rtl/lru_core.sv =====
// resident page list, occupancy and counters with the combinational lookup and registered update
module lru_core import lru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              step,
  input  logic [PAGE_W-1:0] page,
  input  logic [CFG_W-1:0]  frames_in_use,
  output lru_result_t       res
);

  logic [PAGE_W-1:0] frames_r   [MAX_FRAMES];
  logic [PAGE_W-1:0] frames_nxt [MAX_FRAMES];
  logic [PAGE_W-1:0] frames_up  [MAX_FRAMES];
  logic [OCC_W-1:0]  occ_r, occ_nxt;
  logic [CNT_W-1:0]  hit_cnt_r, hit_cnt_nxt;
  logic [CNT_W-1:0]  fault_cnt_r, fault_cnt_nxt;

  logic [OCC_W-1:0]      lim;
  logic [MAX_FRAMES-1:0] match;
  logic                  found;
  logic [OCC_W-1:0]      pos;
  logic                  evict;
  logic                  shift;
  logic [OCC_W-1:0]      rm_pos;
  logic [OCC_W-1:0]      wr_pos;

  // limit clamped to 1..MAX_FRAMES
  always_comb begin
    if (int'(frames_in_use) > MAX_FRAMES) begin
      lim = OCC_W'(MAX_FRAMES);
    end else if (frames_in_use == '0) begin
      lim = OCC_W'(1);
    end else begin
      lim = OCC_W'(frames_in_use);
    end
  end

  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      match[k] = (OCC_W'(k) < occ_r) && (frames_r[k] == page);
    end
  end

  // lowest matching slot wins
  always_comb begin
    pos = '0;
    for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
      if (match[k]) begin
        pos = OCC_W'(k);
      end
    end
  end

  assign found  = |match;
  assign evict  = !found && (occ_r >= lim);
  assign shift  = found || evict;
  assign rm_pos = found ? pos : '0;
  assign wr_pos = shift ? occ_r - OCC_W'(1) : occ_r;

  always_comb begin
    for (int k = 0; k < MAX_FRAMES - 1; k++) begin
      frames_up[k] = frames_r[k+1];
    end
    frames_up[MAX_FRAMES-1] = frames_r[MAX_FRAMES-1];
  end

  // close the gap above the removed slot, new page lands at the most recent slot
  always_comb begin
    for (int k = 0; k < MAX_FRAMES; k++) begin
      if (OCC_W'(k) == wr_pos) begin
        frames_nxt[k] = page;
      end else if (shift && (OCC_W'(k) >= rm_pos)) begin
        frames_nxt[k] = frames_up[k];
      end else begin
        frames_nxt[k] = frames_r[k];
      end
    end
  end

  always_comb begin
    occ_nxt       = shift ? occ_r : occ_r + OCC_W'(1);
    hit_cnt_nxt   = hit_cnt_r;
    fault_cnt_nxt = fault_cnt_r;
    if (found) begin
      if (hit_cnt_r != '1) begin
        hit_cnt_nxt = hit_cnt_r + CNT_W'(1);
      end
    end else begin
      if (fault_cnt_r != '1) begin
        fault_cnt_nxt = fault_cnt_r + CNT_W'(1);
      end
    end
  end

  always_comb begin
    res.hit           = found;
    res.evicted_valid = evict;
    res.evicted_page  = evict ? frames_r[0] : '0;
    res.hit_total     = hit_cnt_nxt;
    res.fault_total   = fault_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r       <= '0;
      hit_cnt_r   <= '0;
      fault_cnt_r <= '0;
    end else if (step) begin
      occ_r       <= occ_nxt;
      hit_cnt_r   <= hit_cnt_nxt;
      fault_cnt_r <= fault_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
        frames_r[k] <= frames_nxt[k];
      end
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    int'(occ_r) <= MAX_FRAMES)
    else $error("occupancy beyond frame count");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    step && !shift |=> occ_r == $past(occ_r) + OCC_W'(1))
    else $error("fill without occupancy increase");

  a_shift_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    step && shift |=> occ_r == $past(occ_r))
    else $error("hit or eviction changed occupancy");

  a_hit_count: assert property (@(posedge clk) disable iff (!rst_n)
    step && found |=> (hit_cnt_r == $past(hit_cnt_r) + CNT_W'(1)) || (hit_cnt_r == '1))
    else $error("hit counter did not advance");

endmodule

// ===== hw/rtl/lru_out_reg.sv =====
// result register for the out channel
module lru_out_reg import lru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  lru_result_t       res,
  output logic              room,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic              out_evicted_valid,
  output logic [PAGE_W-1:0] out_evicted_page,
  output logic [CNT_W-1:0]  out_hit_total,
  output logic [CNT_W-1:0]  out_fault_total
);

  logic        valid_r, valid_nxt;
  lru_result_t res_r;

  assign room = !valid_r || !out_stall;

  always_comb begin
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_stall) begin
      valid_nxt = valid_r;
    end else begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign out_valid         = valid_r;
  assign out_hit           = res_r.hit;
  assign out_evicted_valid = res_r.evicted_valid;
  assign out_evicted_page  = res_r.evicted_page;
  assign out_hit_total     = res_r.hit_total;
  assign out_fault_total   = res_r.fault_total;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && out_stall |-> !load)
    else $error("stalled result overwritten");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("loaded result not presented");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> !(res_r.hit && res_r.evicted_valid))
    else $error("hit and eviction in one beat");

endmodule

// ===== hw/rtl/lru_page_replacement.sv =====
// throughput: one page beat per cycle unless out_stall holds a result; the frame list and
//   counters update in the cycle between the input register and the result register, so
//   back-to-back hits chain; a beat's result is shown on out_valid from the result register
// reset: synchronous active-low rst_n empties the frame list, clears both counters and
//   sets frames_in_use to 4; cfg_ready is always high
// top level of the lru page replacement block: input register, frame list, result register
module lru_page_replacement import lru_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [PAGE_W-1:0] in_page,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_W-1:0]  cfg_frames_in_use,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_hit,
  output logic              out_evicted_valid,
  output logic [PAGE_W-1:0] out_evicted_page,
  output logic [CNT_W-1:0]  out_hit_total,
  output logic [CNT_W-1:0]  out_fault_total
);

  logic              in_valid_r, in_valid_nxt;
  logic [PAGE_W-1:0] in_page_r;
  logic [CFG_W-1:0]  frames_r;
  logic              room;
  logic              step;
  logic              in_take;
  lru_result_t       res;

  assign step     = in_valid_r && room;
  assign in_stall = in_valid_r && !room;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  always_comb begin
    if (in_take) begin
      in_valid_nxt = 1'b1;
    end else if (step) begin
      in_valid_nxt = 1'b0;
    end else begin
      in_valid_nxt = in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
      frames_r   <= FRAMES_RESET;
    end else begin
      in_valid_r <= in_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        frames_r <= cfg_frames_in_use;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_page_r <= in_page;
    end
  end

  lru_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (step),
    .page          (in_page_r),
    .frames_in_use (frames_r),
    .res           (res)
  );

  lru_out_reg u_out (
    .clk               (clk),
    .rst_n             (rst_n),
    .load              (step),
    .res               (res),
    .room              (room),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hit           (out_hit),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_hit_total     (out_hit_total),
    .out_fault_total   (out_fault_total)
  );

  a_stall_held: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> in_valid_r && out_valid && out_stall)
    else $error("input stalled without a blocked result");

  a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> in_valid_r)
    else $error("accepted page beat lost");

  a_step_drains: assert property (@(posedge clk) disable iff (!rst_n)
    step && !in_take |=> !in_valid_r)
    else $error("processed page beat repeated");

endmodule
